FILE: hdl/text_console_terminal_top_assert.svh
// Assertion macros for the terminal RTL.
// No dependencies; included by modules that check their own logic.
`ifndef TEXT_CONSOLE_TERMINAL_TOP_ASSERT_SVH
`define TEXT_CONSOLE_TERMINAL_TOP_ASSERT_SVH
`define TCT_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TCT_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hdl/tct_pkg.sv
// Constants and helper functions for the text console terminal.
// No dependencies.
package tct_pkg;
    localparam int CONSOLES = 4;
    localparam int ROWS = 25;
    localparam int COLUMNS = 80;
    localparam int CELLS = ROWS * COLUMNS;
    localparam int KW = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam int AW = $clog2(CONSOLES * CELLS);
    localparam int MEM_DEPTH = CONSOLES * CELLS;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_CURSOR = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ESC = 2'd1;
    localparam logic [1:0] PH_CSI = 2'd2;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] DEF_COLOR = 8'h07;
    localparam logic [15:0] RESET_CELL = 16'h0720;

    localparam logic [7:0] CHR_BS = 8'h08;
    localparam logic [7:0] CHR_TAB = 8'h09;
    localparam logic [7:0] CHR_LF = 8'h0A;
    localparam logic [7:0] CHR_CR = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO = 8'h30;
    localparam logic [7:0] CHR_NINE = 8'h39;
    localparam logic [7:0] CHR_C = 8'h43;
    localparam logic [7:0] CHR_D = 8'h44;
    localparam logic [7:0] CHR_K = 8'h4B;
    localparam logic [7:0] CHR_LBR = 8'h5B;
    localparam logic [7:0] CHR_M = 8'h6D;

    function automatic logic [8:0] color_of(input logic [7:0] code);
        logic [8:0] v;
        case (code)
            8'd0, 8'd37: v = {1'b1, 8'h07};
            8'd31: v = {1'b1, 8'h04};
            8'd32: v = {1'b1, 8'h02};
            8'd33: v = {1'b1, 8'h06};
            8'd34: v = {1'b1, 8'h01};
            8'd35: v = {1'b1, 8'h05};
            8'd36: v = {1'b1, 8'h03};
            8'd90: v = {1'b1, 8'h08};
            8'd91: v = {1'b1, 8'h0C};
            8'd92: v = {1'b1, 8'h0A};
            8'd93: v = {1'b1, 8'h0E};
            8'd94: v = {1'b1, 8'h09};
            8'd95: v = {1'b1, 8'h0D};
            8'd96: v = {1'b1, 8'h0B};
            8'd97: v = {1'b1, 8'h0F};
            default: v = 9'd0;
        endcase
        return v;
    endfunction
endpackage

FILE: hdl/tct_screen_ram.sv
// Screen cell memory: one write port, one registered read port.
// Depends on tct_pkg.
module tct_screen_ram import tct_pkg::*; (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);
    logic [15:0] mem [MEM_DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: hdl/text_console_terminal_top.sv
// Text console terminal top level: escape parser, cursor logic, sequencer.
// Depends on tct_pkg, tct_screen_ram and text_console_terminal_top_assert.svh.
//
// Channel  Dir  Handshake          Payload
// in       in   i_valid/o_ready    i_mode i_console i_char_byte i_end_of_write i_row i_column
// out      out  o_valid/i_ready    o_cell_res o_cursor_row o_cursor_column o_color o_escape_phase
//
// A cursor set or an escape step that prints nothing goes from S_EXEC to S_DONE; a read
// passes S_RDWAIT and a printed byte S_PLAIN; the next beat is taken back in S_IDLE.
// A byte that scrolls copies rows up through S_SCR_RD/S_SCR_WR, then blanks the last row in
// S_FILL; erase to end of line and clear fill their cells in S_FILL; a printed ESC runs a second byte pass.
// After reset a clearing pass writes all CONSOLES*ROWS*COLUMNS cells before any input.
// A new beat is taken only while the output register is empty or being read out.
`include "text_console_terminal_top_assert.svh"
module text_console_terminal_top import tct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_console,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_write,
    input  logic [4:0]  i_row,
    input  logic [6:0]  i_column,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_cell_res,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_column,
    output logic [7:0]  o_color,
    output logic [1:0]  o_escape_phase
);
    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_EXEC, S_PLAIN, S_RDWAIT, S_SCR_RD, S_SCR_WR, S_FILL, S_DONE
    } t_state;

    t_state r_state;
    logic [CONSOLES-1:0][RW-1:0] r_crow;
    logic [CONSOLES-1:0][CW-1:0] r_ccol;
    logic [CONSOLES-1:0][7:0]    r_colr;
    logic [CONSOLES-1:0][1:0]    r_phase;
    logic [CONSOLES-1:0][7:0]    r_code;

    logic [1:0]    r_mode;
    logic [KW-1:0] r_k;
    logic [7:0]    r_b;
    logic          r_last;
    logic [RW-1:0] r_r;
    logic [CW-1:0] r_c;
    logic [7:0]    r_pb;
    logic          r_has_second;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_end;

    logic          r_ovalid;
    logic          r_bad;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;

    tct_screen_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic accept_in;
    logic done_fire;
    assign o_ready = (r_state == S_IDLE) && (!r_ovalid || i_ready);
    assign accept_in = i_valid && o_ready;
    assign done_fire = (r_state == S_DONE) && (!r_ovalid || i_ready);
    assign o_valid = r_ovalid;

    logic [RW-1:0] cur_r;
    logic [CW-1:0] cur_c;
    logic [AW-1:0] kbase;
    logic [15:0]   blank;
    assign cur_r = r_crow[r_k];
    assign cur_c = r_ccol[r_k];
    assign kbase = AW'(r_k) * AW'(CELLS);
    assign blank = {r_colr[r_k], CHR_SPACE};

    function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] b,
                                              input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
        return b + AW'(r) * AW'(COLUMNS) + AW'(c);
    endfunction

    logic [CW:0] tabc;
    assign tabc = ({1'b0, cur_c} + (CW+1)'(8)) & ~(CW+1)'(7);

    logic [11:0] code_acc;
    logic [8:0]  sgr;
    assign code_acc = 12'(r_code[r_k]) * 12'd10 + 12'(r_b - CHR_ZERO);
    assign sgr = color_of(r_code[r_k]);

    logic          plain_nl;
    logic [CW-1:0] plain_col;

    always_comb begin
        plain_nl = 1'b0;
        plain_col = cur_c;
        case (r_pb)
            CHR_LF: plain_nl = 1'b1;
            CHR_CR: plain_col = '0;
            CHR_TAB: begin
                if (tabc >= (CW+1)'(COLUMNS)) plain_nl = 1'b1;
                else plain_col = CW'(tabc);
            end
            CHR_BS: begin
                if (cur_c != '0) plain_col = cur_c - 1'b1;
            end
            default: begin
                if (cur_c == CW'(COLUMNS - 1)) plain_nl = 1'b1;
                else plain_col = cur_c + 1'b1;
            end
        endcase
        if (plain_nl) plain_col = '0;
    end

    always_comb begin
        we = 1'b0;
        waddr = r_ptr;
        wdata = blank;
        raddr = r_ptr;
        case (r_state)
            S_INIT: begin
                we = 1'b1;
                wdata = RESET_CELL;
            end
            S_PLAIN: begin
                if (r_pb == CHR_BS) begin
                    we = (cur_c != '0);
                    waddr = addr_of(kbase, cur_r, cur_c - 1'b1);
                end else begin
                    we = !(r_pb inside {CHR_LF, CHR_CR, CHR_TAB});
                    waddr = addr_of(kbase, cur_r, cur_c);
                    wdata = {r_colr[r_k], r_pb};
                end
            end
            S_SCR_WR: begin
                we = 1'b1;
                waddr = r_ptr - AW'(COLUMNS);
                wdata = rdata;
            end
            S_FILL: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr <= '0;
            r_end <= '0;
            r_ovalid <= 1'b0;
            r_k <= '0;
            r_has_second <= 1'b0;
            o_cell_res <= '0;
            o_cursor_row <= '0;
            o_cursor_column <= '0;
            o_color <= '0;
            o_escape_phase <= '0;
            for (int i = 0; i < CONSOLES; i++) begin
                r_crow[i] <= '0;
                r_ccol[i] <= '0;
                r_colr[i] <= DEF_COLOR;
                r_phase[i] <= PH_IDLE;
                r_code[i] <= '0;
            end
        end else begin
            r_ovalid <= done_fire || (r_ovalid && !i_ready);
            case (r_state)
                S_INIT: begin
                    if (r_ptr == AW'(MEM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept_in) begin
                        r_mode <= i_mode;
                        r_k <= KW'(i_console);
                        r_b <= i_char_byte;
                        r_last <= i_end_of_write;
                        r_r <= (i_row >= 5'(ROWS)) ? RW'(ROWS - 1) : RW'(i_row);
                        r_c <= (i_column >= 7'(COLUMNS)) ? CW'(COLUMNS - 1)
                                                        : CW'(i_column);
                        r_bad <= (32'(i_console) >= CONSOLES);
                        r_has_second <= 1'b0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_bad) begin
                        r_state <= S_DONE;
                    end else begin
                        case (r_mode)
                            MODE_READ: begin
                                r_ptr <= addr_of(kbase, r_r, r_c);
                                r_state <= S_RDWAIT;
                            end
                            MODE_CURSOR: begin
                                r_crow[r_k] <= r_r;
                                r_ccol[r_k] <= r_c;
                                r_state <= S_DONE;
                            end
                            MODE_CLEAR: begin
                                r_crow[r_k] <= '0;
                                r_ccol[r_k] <= '0;
                                r_ptr <= kbase;
                                r_end <= kbase + AW'(CELLS - 1);
                                r_state <= S_FILL;
                            end
                            default: begin
                                if (r_phase[r_k] == PH_ESC) begin
                                    if (r_b == CHR_LBR) begin
                                        r_code[r_k] <= '0;
                                        r_phase[r_k] <= r_last ? PH_IDLE : PH_CSI;
                                        r_state <= S_DONE;
                                    end else begin
                                        // The pending ESC prints first, then the byte
                                        // is handled again with no escape pending.
                                        r_phase[r_k] <= PH_IDLE;
                                        r_pb <= ESC_BYTE;
                                        r_has_second <= 1'b1;
                                        r_state <= S_PLAIN;
                                    end
                                end else if (r_phase[r_k] == PH_CSI) begin
                                    if (r_b inside {[CHR_ZERO:CHR_NINE]}) begin
                                        r_code[r_k] <= (code_acc > 12'd255) ? 8'hFF
                                                                            : code_acc[7:0];
                                        if (r_last) r_phase[r_k] <= PH_IDLE;
                                        r_state <= S_DONE;
                                    end else begin
                                        r_phase[r_k] <= PH_IDLE;
                                        r_state <= (r_b == CHR_K) ? S_FILL : S_DONE;
                                        if (r_b == CHR_M) begin
                                            if (sgr[8]) r_colr[r_k] <= sgr[7:0];
                                        end else if (r_b == CHR_K) begin
                                            r_ptr <= addr_of(kbase, cur_r, cur_c);
                                            r_end <= addr_of(kbase, cur_r,
                                                             CW'(COLUMNS - 1));
                                        end else if (r_b == CHR_D) begin
                                            if (cur_c != '0) r_ccol[r_k] <= cur_c - 1'b1;
                                        end else if (r_b == CHR_C) begin
                                            if (cur_c != CW'(COLUMNS - 1))
                                                r_ccol[r_k] <= cur_c + 1'b1;
                                        end
                                    end
                                end else begin
                                    r_has_second <= 1'b0;
                                    if (r_b == ESC_BYTE && !r_last) begin
                                        r_phase[r_k] <= PH_ESC;
                                        r_state <= S_DONE;
                                    end else begin
                                        r_phase[r_k] <= PH_IDLE;
                                        r_pb <= r_b;
                                        r_state <= S_PLAIN;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_PLAIN: begin
                    r_ccol[r_k] <= plain_col;
                    if (plain_nl && cur_r == RW'(ROWS - 1)) begin
                        r_ptr <= kbase + AW'(COLUMNS);
                        r_state <= S_SCR_RD;
                    end else begin
                        if (plain_nl) r_crow[r_k] <= cur_r + 1'b1;
                        r_state <= r_has_second ? S_EXEC : S_DONE;
                    end
                end
                S_RDWAIT: begin
                    r_state <= S_DONE;
                end
                S_SCR_RD: begin
                    r_state <= S_SCR_WR;
                end
                S_SCR_WR: begin
                    if (r_ptr == kbase + AW'(CELLS - 1)) begin
                        r_ptr <= kbase + AW'(CELLS - COLUMNS);
                        r_end <= kbase + AW'(CELLS - 1);
                        r_crow[r_k] <= RW'(ROWS - 1);
                        r_state <= S_FILL;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                        r_state <= S_SCR_RD;
                    end
                end
                S_FILL: begin
                    if (r_ptr == r_end) begin
                        r_state <= r_has_second ? S_EXEC : S_DONE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_DONE: begin
                    if (done_fire) begin
                        r_state <= S_IDLE;
                        if (r_bad) begin
                            o_cell_res <= '0;
                            o_cursor_row <= '0;
                            o_cursor_column <= '0;
                            o_color <= '0;
                            o_escape_phase <= '0;
                        end else begin
                            o_cell_res <= (r_mode == MODE_READ) ? rdata : 16'h0;
                            o_cursor_row <= 5'(cur_r);
                            o_cursor_column <= 7'(cur_c);
                            o_color <= r_colr[r_k];
                            o_escape_phase <= r_phase[r_k];
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `TCT_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `TCT_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, accept_in, r_state == S_EXEC)
    `TCT_ASSERT_NXT(a_valid_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `TCT_ASSERT_IMP(a_col_range, i_clk, i_rst_n, 1'b1, cur_c < CW'(COLUMNS))
    `TCT_ASSERT_IMP(a_phase_range, i_clk, i_rst_n, 1'b1,
                    r_phase[r_k] == PH_IDLE || r_phase[r_k] == PH_ESC ||
                    r_phase[r_k] == PH_CSI)
endmodule

FILE: dv/tb_text_console_terminal_top.sv
// Self-checking testbench for text_console_terminal_top: directed and random beats
// are predicted by a behavioral screen model and compared with every result beat.
// Depends on tct_pkg and the terminal RTL.
module tb_text_console_terminal_top import tct_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 60000;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_M = 8'h6D;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_C = 8'h43;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] con;
        logic [7:0] ch;
        logic       eow;
        logic [4:0] row;
        logic [6:0] col;
    } term_cmd_t;

    typedef struct packed {
        logic [15:0] cdata;
        logic [4:0]  row;
        logic [6:0]  col;
        logic [7:0]  color;
        logic [1:0]  phase;
    } term_status_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode = '0;
    logic [1:0]  i_console = '0;
    logic [7:0]  i_char_byte = '0;
    logic        i_end_of_write = 1'b0;
    logic [4:0]  i_row = '0;
    logic [6:0]  i_column = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_cell_res;
    logic [4:0]  o_cursor_row;
    logic [6:0]  o_cursor_column;
    logic [7:0]  o_color;
    logic [1:0]  o_escape_phase;

    text_console_terminal_top i_dut (.*);

    logic [15:0] screen [MEM_DEPTH];
    logic [4:0]  cur_row [CONSOLES];
    logic [6:0]  cur_col [CONSOLES];
    logic [7:0]  attr [CONSOLES];
    logic [1:0]  esc_phase [CONSOLES];
    logic [7:0]  esc_code [CONSOLES];

    term_status_t expected_status[$];
    int mismatches = 0;
    int stall_cycles = 0;
    bit steady = 1'b0;
    int ready_hold = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] blank_cell(int k);
        return {attr[k], 8'h20};
    endfunction

    function automatic void scroll_screen(int k);
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[k * CELLS + i] = screen[k * CELLS + i + COLUMNS];
        for (int c = 0; c < COLUMNS; c++)
            screen[k * CELLS + (ROWS - 1) * COLUMNS + c] = blank_cell(k);
        cur_row[k] = 5'(ROWS - 1);
    endfunction

    function automatic void line_feed(int k);
        cur_col[k] = '0;
        if (int'(cur_row[k]) + 1 >= ROWS) scroll_screen(k);
        else cur_row[k] = cur_row[k] + 5'd1;
    endfunction

    function automatic void put_plain(int k, logic [7:0] b);
        int c;
        c = int'(cur_col[k]);
        if (b == CH_LF) begin
            line_feed(k);
        end else if (b == CH_CR) begin
            cur_col[k] = '0;
        end else if (b == CH_TAB) begin
            c = (c + 8) & ~7;
            if (c >= COLUMNS) line_feed(k);
            else cur_col[k] = 7'(c);
        end else if (b == CH_BS) begin
            if (c > 0) begin
                cur_col[k] = 7'(c - 1);
                screen[k * CELLS + int'(cur_row[k]) * COLUMNS + c - 1] = blank_cell(k);
            end
        end else begin
            screen[k * CELLS + int'(cur_row[k]) * COLUMNS + c] = {attr[k], b};
            if (c + 1 >= COLUMNS) line_feed(k);
            else cur_col[k] = 7'(c + 1);
        end
    endfunction

    function automatic void apply_sgr(int k, logic [7:0] code);
        case (code)
            8'd0, 8'd37: attr[k] = 8'h07;
            8'd31: attr[k] = 8'h04;
            8'd32: attr[k] = 8'h02;
            8'd33: attr[k] = 8'h06;
            8'd34: attr[k] = 8'h01;
            8'd35: attr[k] = 8'h05;
            8'd36: attr[k] = 8'h03;
            8'd90: attr[k] = 8'h08;
            8'd91: attr[k] = 8'h0C;
            8'd92: attr[k] = 8'h0A;
            8'd93: attr[k] = 8'h0E;
            8'd94: attr[k] = 8'h09;
            8'd95: attr[k] = 8'h0D;
            8'd96: attr[k] = 8'h0B;
            8'd97: attr[k] = 8'h0F;
            default: ;
        endcase
    endfunction

    function automatic void csi_end(int k, logic [7:0] b);
        if (b == CH_M) begin
            apply_sgr(k, esc_code[k]);
        end else if (b == CH_K) begin
            for (int c = int'(cur_col[k]); c < COLUMNS; c++)
                screen[k * CELLS + int'(cur_row[k]) * COLUMNS + c] = blank_cell(k);
        end else if (b == CH_D) begin
            if (cur_col[k] > 0) cur_col[k] = cur_col[k] - 7'd1;
        end else if (b == CH_C) begin
            if (int'(cur_col[k]) + 1 < COLUMNS) cur_col[k] = cur_col[k] + 7'd1;
        end
    endfunction

    function automatic void idle_char(int k, logic [7:0] b, logic eow);
        if (b == ESC_BYTE && !eow) esc_phase[k] = PH_ESC;
        else put_plain(k, b);
    endfunction

    function automatic void write_char(int k, logic [7:0] b, logic eow);
        int v;
        if (esc_phase[k] == PH_ESC) begin
            if (b == CH_LBR) begin
                esc_code[k] = '0;
                esc_phase[k] = eow ? PH_IDLE : PH_CSI;
            end else begin
                esc_phase[k] = PH_IDLE;
                put_plain(k, ESC_BYTE);
                idle_char(k, b, eow);
            end
        end else if (esc_phase[k] == PH_CSI) begin
            if (b >= "0" && b <= "9") begin
                v = int'(esc_code[k]) * 10 + int'(b - "0");
                esc_code[k] = (v > 255) ? 8'd255 : v[7:0];
                if (eow) esc_phase[k] = PH_IDLE;
            end else begin
                esc_phase[k] = PH_IDLE;
                csi_end(k, b);
            end
        end else begin
            esc_phase[k] = PH_IDLE;
            idle_char(k, b, eow);
        end
    endfunction

    function automatic term_status_t terminal_step(term_cmd_t cmd);
        term_status_t s;
        int k, r, c;
        s = '0;
        k = int'(cmd.con);
        if (k >= CONSOLES) return s;
        r = (int'(cmd.row) >= ROWS) ? ROWS - 1 : int'(cmd.row);
        c = (int'(cmd.col) >= COLUMNS) ? COLUMNS - 1 : int'(cmd.col);
        case (cmd.mode)
            MODE_WRITE: write_char(k, cmd.ch, cmd.eow);
            MODE_READ: s.cdata = screen[k * CELLS + r * COLUMNS + c];
            MODE_CURSOR: begin
                cur_row[k] = 5'(r);
                cur_col[k] = 7'(c);
            end
            default: begin
                for (int i = 0; i < CELLS; i++) screen[k * CELLS + i] = blank_cell(k);
                cur_row[k] = '0;
                cur_col[k] = '0;
            end
        endcase
        s.row = cur_row[k];
        s.col = cur_col[k];
        s.color = attr[k];
        s.phase = esc_phase[k];
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_cmd(term_cmd_t cmd);
        int gap;
        bit rdy;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= cmd.mode;
        i_console <= cmd.con;
        i_char_byte <= cmd.ch;
        i_end_of_write <= cmd.eow;
        i_row <= cmd.row;
        i_column <= cmd.col;
        do begin
            @(negedge i_clk);
            rdy = o_ready;
            @(posedge i_clk);
        end while (!rdy);
        expected_status.push_back(terminal_step(cmd));
    endtask

    task automatic put_byte(logic [1:0] k, logic [7:0] b, logic eow);
        send_cmd('{MODE_WRITE, k, b, eow, 5'($urandom), 7'($urandom)});
    endtask

    task automatic put_other(logic [1:0] mode, logic [1:0] k, logic [4:0] r, logic [6:0] c);
        send_cmd('{mode, k, 8'($urandom), 1'($urandom), r, c});
    endtask

    task automatic test_directed();
        put_other(MODE_READ, 0, 0, 0);
        put_other(MODE_READ, 1, 5'd31, 7'd127);
        put_byte(0, 8'h00, 0);
        put_byte(0, 8'hFF, 0);
        put_byte(0, CH_TAB, 0);
        put_byte(0, CH_BS, 0);
        put_byte(0, CH_CR, 0);
        put_byte(0, CH_BS, 1);
        put_byte(0, CH_LF, 0);
        put_byte(1, ESC_BYTE, 0);
        put_byte(1, CH_LBR, 0);
        put_byte(1, "3", 0);
        put_other(MODE_READ, 1, 0, 0);
        put_byte(1, "1", 0);
        put_byte(1, CH_M, 1);
        put_byte(1, "A", 0);
        put_byte(1, ESC_BYTE, 0);
        put_byte(1, "x", 1);
        put_byte(2, ESC_BYTE, 1);
        put_byte(2, ESC_BYTE, 0);
        put_byte(2, CH_LBR, 0);
        put_byte(2, "9", 0);
        put_byte(2, "9", 0);
        put_byte(2, "9", 1);
        put_other(MODE_CURSOR, 3, 5'd30, 7'd120);
        put_byte(3, "Z", 1);
        put_other(MODE_READ, 3, 24, 79);
        put_other(MODE_CLEAR, 3, 0, 0);
        put_other(MODE_READ, 3, 24, 0);
    endtask

    task automatic put_sequence(logic [1:0] k);
        logic [7:0] seq [$];
        logic [7:0] fin;
        string digits;
        int code, n;
        seq.push_back(ESC_BYTE);
        if ($urandom_range(0, 9) == 0) seq.push_back(8'($urandom));
        else seq.push_back(CH_LBR);
        case ($urandom_range(0, 3))
            0: code = $urandom_range(30, 37);
            1: code = $urandom_range(90, 97);
            2: code = $urandom_range(0, 9);
            default: code = $urandom_range(0, 999);
        endcase
        digits = $sformatf("%0d", code);
        if ($urandom_range(0, 4) != 0)
            foreach (digits[i]) seq.push_back(digits[i]);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: fin = CH_M;
            5: fin = CH_K;
            6: fin = CH_D;
            7: fin = CH_C;
            default: fin = 8'($urandom);
        endcase
        seq.push_back(fin);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, seq.size()) : seq.size();
        for (int i = 0; i < n; i++)
            put_byte(k, seq[i], (i == n - 1) && ($urandom_range(0, 2) != 0));
    endtask

    task automatic test_random_traffic(int count);
        logic [1:0] k;
        logic [7:0] b;
        int sel;
        for (int i = 0; i < count; i++) begin
            k = 2'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                put_sequence(k);
            end else if (sel < 70) begin
                b = 8'($urandom_range(8'h20, 8'h7E));
                if ($urandom_range(0, 3) == 0) b = 8'($urandom);
                put_byte(k, b, 1'($urandom));
            end else if (sel < 76) begin
                case ($urandom_range(0, 3))
                    0: b = CH_LF;
                    1: b = CH_CR;
                    2: b = CH_TAB;
                    default: b = CH_BS;
                endcase
                put_byte(k, b, 1'($urandom));
            end else if (sel < 88) begin
                put_other(MODE_READ, k, 5'($urandom), 7'($urandom));
            end else if (sel < 99) begin
                put_other(MODE_CURSOR, k, 5'($urandom_range(0, 23)), 7'($urandom));
            end else begin
                put_other(MODE_CLEAR, k, 5'($urandom), 7'($urandom));
            end
        end
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        test_random_traffic(60);
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 2) != 0);
            ready_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                        : $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        term_status_t got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_cell_res, o_cursor_row, o_cursor_column, o_color, o_escape_phase};
            if (expected_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat %h", got);
            end else begin
                want = expected_status.pop_front();
                if (got.cdata !== want.cdata || got.row !== want.row || got.col !== want.col
                        || got.color !== want.color || got.phase !== want.phase) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: cell %h/%h row %0d/%0d col %0d/%0d ",
                                  "color %h/%h phase %0d/%0d (exp/act)"},
                            want.cdata, got.cdata, want.row, got.row, want.col, got.col,
                            want.color, got.color, want.phase, got.phase);
                end
            end
        end
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        foreach (screen[i]) screen[i] = RESET_CELL;
        for (int k = 0; k < CONSOLES; k++) begin
            cur_row[k] = '0;
            cur_col[k] = '0;
            attr[k] = DEF_COLOR;
            esc_phase[k] = PH_IDLE;
            esc_code[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic(200);
        test_back_to_back();
        test_random_traffic(45);
        i_valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

FILE: text_console_terminal_top.f
+incdir+hdl
hdl/tct_pkg.sv
hdl/tct_screen_ram.sv
hdl/text_console_terminal_top.sv
dv/tb_text_console_terminal_top.sv
